/* hw/rtl/vqn_pkg.sv */
// Shared constants and the item type handed along the cell chain.
`default_nettype none

package vqn_pkg;

    localparam int VECTOR_LENGTH = 14;
    localparam int IDX_W         = 4;
    localparam int SAMPLE_W      = 32;
    localparam int QUANT_W       = 15;
    localparam int MAG_W         = 14;
    localparam int SUM_W         = 30;
    localparam int ROOT_W        = 15;
    localparam int REM_W         = 17;
    localparam int SQRT_CELLS    = ROOT_W;

    localparam logic [IDX_W-1:0] POS_SIGN_LO = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_SIGN_HI = IDX_W'(6);
    localparam logic [IDX_W-1:0] POS_STEP_LO = IDX_W'(9);
    localparam logic [IDX_W-1:0] POS_STEP_HI = IDX_W'(11);
    localparam logic [IDX_W-1:0] POS_LAST    = IDX_W'(VECTOR_LENGTH - 1);

    localparam logic signed [QUANT_W-1:0]  QUANT_ONE  = 15'sd8192;
    localparam logic signed [SAMPLE_W-1:0] HALF_RAW   = 32'sd32768;
    localparam logic signed [SAMPLE_W-1:0] ONE_RAW    = 32'sd65536;
    localparam logic [SUM_W:0]             SUM_MAX    = {1'b0, {SUM_W{1'b1}}};

    typedef struct packed {
        logic signed [QUANT_W-1:0] quantized;
        logic                      vector_end;
        logic [SUM_W-1:0]          norm_squared;
        logic [SUM_W-1:0]          radicand;
        logic [REM_W-1:0]          rem;
        logic [ROOT_W-1:0]         root;
    } vqn_item_t;

endpackage

`default_nettype wire

/* hw/rtl/vqn_quant_cell.sv */
// Head cell: quantizes one element and keeps the running sum of squares.
`default_nettype none

module vqn_quant_cell
    import vqn_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       valid_in,
    output logic                            ready_out,
    input  wire logic signed [SAMPLE_W-1:0] sample_value,
    output logic                            valid_out,
    input  wire logic                       ready_in,
    output vqn_item_t                       item_out
);

    logic                      valid_reg;
    vqn_item_t                 item_reg;
    vqn_item_t                 item_next;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_next;
    logic [SUM_W-1:0]          sum_reg;
    logic [SUM_W-1:0]          sum_next;
    logic signed [QUANT_W-1:0] q;
    logic [16:0]               clamped;
    logic [17:0]               rounded;
    logic [MAG_W-1:0]          mag;
    logic [2*MAG_W-1:0]        sq;
    logic [SUM_W:0]            sum_wide;
    logic [SUM_W-1:0]          sum_sat;
    logic                      last;
    logic                      accept;

    assign ready_out = !valid_reg || ready_in;
    assign accept    = valid_in && ready_out;
    assign valid_out = valid_reg;
    assign item_out  = item_reg;

    always_comb
    begin
        if (sample_value[SAMPLE_W-1])
            clamped = '0;
        else if (sample_value > ONE_RAW)
            clamped = 17'h10000;
        else
            clamped = sample_value[16:0];
        rounded = {1'b0, clamped} + 18'd4;

        if ((idx_reg == POS_SIGN_LO || idx_reg == POS_SIGN_HI) && sample_value[SAMPLE_W-1])
            q = -QUANT_ONE;
        else if (idx_reg >= POS_STEP_LO && idx_reg <= POS_STEP_HI)
            q = (sample_value > HALF_RAW) ? QUANT_ONE : '0;
        else
            q = signed'(rounded[17:3]);

        mag      = q[QUANT_W-1] ? MAG_W'(-q) : q[MAG_W-1:0];
        sq       = mag * mag;
        sum_wide = {1'b0, sum_reg} + {{(SUM_W + 1 - 2*MAG_W){1'b0}}, sq};
        sum_sat  = (sum_wide > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sum_wide[SUM_W-1:0];
        last     = idx_reg >= POS_LAST;

        item_next.quantized    = q;
        item_next.vector_end   = last;
        item_next.norm_squared = last ? sum_sat : '0;
        item_next.radicand     = last ? sum_sat : '0;
        item_next.rem          = '0;
        item_next.root         = '0;

        idx_next = last ? '0 : idx_reg + IDX_W'(1);
        sum_next = last ? '0 : sum_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            sum_reg   <= '0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
        end
        else if (ready_in)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/vqn_sqrt_cell.sv */
// Root cell: settles one bit of the floor square root and passes the item on.
`default_nettype none

module vqn_sqrt_cell
    import vqn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      valid_in,
    output logic           ready_out,
    input  wire vqn_item_t item_in,
    output logic           valid_out,
    input  wire logic      ready_in,
    output vqn_item_t      item_out
);

    logic          valid_reg;
    vqn_item_t     item_reg;
    vqn_item_t     item_next;
    logic [REM_W:0] rem_shift;
    logic [REM_W:0] trial;
    logic           accept;

    assign ready_out = !valid_reg || ready_in;
    assign accept    = valid_in && ready_out;
    assign valid_out = valid_reg;
    assign item_out  = item_reg;

    // remainder stays below 2*root+1, so 16 bits of it carry into the shift
    always_comb
    begin
        item_next  = item_in;
        rem_shift  = {item_in.rem[REM_W-2:0], item_in.radicand[SUM_W-1:SUM_W-2]};
        trial      = {1'b0, item_in.root, 2'b01};
        item_next.radicand = {item_in.radicand[SUM_W-3:0], 2'b00};
        if (rem_shift >= trial)
        begin
            item_next.rem  = REM_W'(rem_shift - trial);
            item_next.root = {item_in.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            item_next.rem  = rem_shift[REM_W-1:0];
            item_next.root = {item_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (ready_in)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/vector_quantize_and_norm.sv */
// Input to result passes one quantize cell and then 15 root cells.
// Throughput: one item per cycle while out_ready is high; a cell frees once its item is taken.
// The square root is resolved one bit per cell along the chain; the chain length sets latency.
// Reset (rst_n, async low) empties the chain and clears the element position and sum.
// A stalled output backs up cell by cell; the input stalls only when every cell is full.
`default_nettype none

module vector_quantize_and_norm
    import vqn_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] sample_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [QUANT_W-1:0]       quantized,
    output logic                            vector_end,
    output logic [SUM_W-1:0]                norm_squared,
    output logic [ROOT_W-1:0]               norm_root
);

    vqn_item_t items [SQRT_CELLS+1];
    logic      valids[SQRT_CELLS+1];
    logic      readys[SQRT_CELLS+1];

    vqn_quant_cell u_quant (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_in     (in_valid),
        .ready_out    (in_ready),
        .sample_value (sample_value),
        .valid_out    (valids[0]),
        .ready_in     (readys[0]),
        .item_out     (items[0])
    );

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_root
        vqn_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valids[i]),
            .ready_out (readys[i]),
            .item_in   (items[i]),
            .valid_out (valids[i+1]),
            .ready_in  (readys[i+1]),
            .item_out  (items[i+1])
        );
    end

    assign readys[SQRT_CELLS] = out_ready;
    assign out_valid          = valids[SQRT_CELLS];
    assign quantized          = items[SQRT_CELLS].quantized;
    assign vector_end         = items[SQRT_CELLS].vector_end;
    assign norm_squared       = items[SQRT_CELLS].norm_squared;
    assign norm_root          = items[SQRT_CELLS].root;

endmodule

`default_nettype wire

/* hw/rtl/vqn_checker.sv */
// Port-level checks for vector_quantize_and_norm, bound to the top level.
`default_nettype none

module vqn_checker
    import vqn_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic signed [SAMPLE_W-1:0] sample_value,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic signed [QUANT_W-1:0]  quantized,
    input  wire logic                       vector_end,
    input  wire logic [SUM_W-1:0]           norm_squared,
    input  wire logic [ROOT_W-1:0]          norm_root
);

    logic [31:0] root_sq;
    logic [31:0] root1_sq;

    assign root_sq  = {17'd0, norm_root} * {17'd0, norm_root};
    assign root1_sq = ({17'd0, norm_root} + 32'd1) * ({17'd0, norm_root} + 32'd1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quantized) && $stable(norm_squared))
        else $error("result item dropped or changed while stalled");

    a_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !vector_end |-> norm_squared == '0 && norm_root == '0)
        else $error("norm fields nonzero on a non-final item");

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && vector_end |-> root_sq <= {2'b00, norm_squared}
                                     && root1_sq > {2'b00, norm_squared})
        else $error("norm_root is not the floor square root");

    a_quant_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quantized >= -QUANT_ONE && quantized <= QUANT_ONE)
        else $error("quantized value out of range");

    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid straight out of reset");

endmodule

bind vector_quantize_and_norm vqn_checker u_vqn_checker (.*);

`default_nettype wire
